[sv/mlfs_pkg.sv]
// shared types and constants for the multilevel feedback scheduler
`timescale 1ns / 1ps
package mlfs_pkg;

  localparam int ID_W        = 4;
  localparam int NEED_W      = 16;
  localparam int LVL_OUT_W   = 3;
  localparam int ENTRY_W     = ID_W + NEED_W;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic {
    OP_ARRIVE = 1'b0,
    OP_TICK   = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_RAN    = 2'd1,
    ST_IDLE   = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEL,
    S_READ,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic capture;
    logic arrive;
    logic requeue;
    logic select;
    logic pop;
    logic res_ld;
    logic out_ld;
    logic out_hold;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic none_ready;
  } stat_t;

endpackage

[sv/mlfs_ram.sv]
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module mlfs_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/mlfs_ctrl.sv]
// sequencing state machine and handshake control for the scheduler
`timescale 1ns / 1ps
module mlfs_ctrl import mlfs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  output logic  out_tvalid,
  input  logic  out_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   produce;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    produce   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_tick) begin
          cmd.requeue = 1'b1;
          state_nxt   = S_SEL;
        end else begin
          cmd.arrive = 1'b1;
          produce    = 1'b1;
        end
      end
      S_SEL: begin
        cmd.select = 1'b1;
        if (stat.none_ready) begin
          produce = 1'b1;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.pop = 1'b1;
        produce = 1'b1;
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_hold = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (produce) begin
      if (out_free) begin
        cmd.out_ld = 1'b1;
        state_nxt  = S_IDLE;
      end else begin
        cmd.res_ld = 1'b1;
        state_nxt  = S_HOLD;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule

[sv/mlfs_dp.sv]
// queue bookkeeping, task memory and result registers of the scheduler
`timescale 1ns / 1ps
module mlfs_dp import mlfs_pkg::*; #(
  parameter int MAX_TASKS  = 16,
  parameter int NUM_LEVELS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  input  logic                   in_tuser,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]             out_tuser
);

  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int IDX_W  = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int ADDR_W = LVL_W + IDX_W;
  localparam int DEPTH  = NUM_LEVELS * (2 ** IDX_W);

  logic [IDX_W-1:0]  head_r  [NUM_LEVELS];
  logic [CNT_W-1:0]  count_r [NUM_LEVELS];
  logic [CNT_W-1:0]  active_r;
  logic              pend_valid_r;
  logic [ID_W-1:0]   pend_id_r;
  logic [NEED_W-1:0] pend_need_r;
  logic [LVL_W-1:0]  pend_lvl_r;
  logic              opcode_r;
  logic [ID_W-1:0]   task_id_r;
  logic [NEED_W-1:0] need_r;
  logic [LVL_W-1:0]  sel_lvl_r;

  logic [1:0]        res_status_r, res_status_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic [2:0]        res_lvl_r, res_lvl_nxt;
  logic              res_fin_r, res_fin_nxt;
  logic [1:0]        out_status_r;
  logic [ID_W-1:0]   out_id_r;
  logic [2:0]        out_lvl_r;
  logic              out_fin_r;

  logic              full;
  logic [LVL_W-1:0]  rq_lvl;
  logic [LVL_W-1:0]  push_lvl;
  logic [IDX_W-1:0]  push_tail;
  logic [SUM_W-1:0]  tail_sum;
  logic              push_ok;
  logic              do_push;
  logic [ENTRY_W-1:0] push_data;
  logic [LVL_W-1:0]  find_lvl;
  logic              none_ready;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [ENTRY_W-1:0] rdata;
  logic [ID_W-1:0]   rd_id;
  logic [NEED_W-1:0] rd_need;
  logic              rd_fin;
  logic [31:0]       sel_lvl_ext;

  assign full = (active_r >= CNT_W'(MAX_TASKS));

  always_comb begin
    rq_lvl = pend_lvl_r;
    if (!(pend_lvl_r == '0 && active_r == CNT_W'(1))) begin
      if (32'(pend_lvl_r) + 32'd1 < 32'(NUM_LEVELS)) begin
        rq_lvl = pend_lvl_r + LVL_W'(1);
      end else begin
        rq_lvl = LVL_W'(NUM_LEVELS - 1);
      end
    end
  end

  always_comb begin
    push_lvl  = cmd.requeue ? rq_lvl : '0;
    push_data = cmd.requeue ? {pend_need_r, pend_id_r} : {need_r, task_id_r};
    tail_sum  = SUM_W'(head_r[push_lvl]) + SUM_W'(count_r[push_lvl]);
    if (tail_sum >= SUM_W'(MAX_TASKS)) begin
      tail_sum = tail_sum - SUM_W'(MAX_TASKS);
    end
    push_tail = tail_sum[IDX_W-1:0];
    push_ok   = (count_r[push_lvl] < CNT_W'(MAX_TASKS));
    do_push   = push_ok && ((cmd.arrive && !full) || (cmd.requeue && pend_valid_r));
  end

  always_comb begin
    find_lvl   = '0;
    none_ready = 1'b1;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (count_r[i] != '0) begin
        find_lvl   = LVL_W'(i);
        none_ready = 1'b0;
      end
    end
  end

  assign waddr = {push_lvl, push_tail};
  assign raddr = {find_lvl, head_r[find_lvl]};

  mlfs_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (do_push),
    .waddr(waddr),
    .wdata(push_data),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_id   = rdata[ID_W-1:0];
  assign rd_need = rdata[ENTRY_W-1:ID_W];
  assign rd_fin  = (rd_need <= NEED_W'(1));

  assign stat.is_tick    = opcode_r;
  assign stat.none_ready = none_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
      end
      active_r     <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      if (do_push) begin
        count_r[push_lvl] <= count_r[push_lvl] + CNT_W'(1);
      end
      if (cmd.arrive && !full) begin
        active_r <= active_r + CNT_W'(1);
      end
      if (cmd.requeue) begin
        pend_valid_r <= 1'b0;
      end
      if (cmd.pop) begin
        if (head_r[sel_lvl_r] == IDX_W'(MAX_TASKS - 1)) begin
          head_r[sel_lvl_r] <= '0;
        end else begin
          head_r[sel_lvl_r] <= head_r[sel_lvl_r] + IDX_W'(1);
        end
        count_r[sel_lvl_r] <= count_r[sel_lvl_r] - CNT_W'(1);
        if (rd_fin) begin
          if (active_r != '0) begin
            active_r <= active_r - CNT_W'(1);
          end
        end else begin
          pend_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      opcode_r  <= in_tuser;
      task_id_r <= in_tdata[ID_W-1:0];
      need_r    <= in_tdata[ENTRY_W-1:ID_W];
    end
    if (cmd.select) begin
      sel_lvl_r <= find_lvl;
    end
    if (cmd.pop && !rd_fin) begin
      pend_id_r   <= rd_id;
      pend_need_r <= rd_need - NEED_W'(1);
      pend_lvl_r  <= sel_lvl_r;
    end
  end

  assign sel_lvl_ext = 32'(sel_lvl_r);

  always_comb begin
    res_status_nxt = ST_IDLE;
    res_id_nxt     = '0;
    res_lvl_nxt    = '0;
    res_fin_nxt    = 1'b0;
    if (cmd.pop) begin
      res_status_nxt = ST_RAN;
      res_id_nxt     = rd_id;
      res_lvl_nxt    = sel_lvl_ext[LVL_OUT_W-1:0];
      res_fin_nxt    = rd_fin;
    end else if (cmd.arrive) begin
      res_status_nxt = full ? ST_FULL : ST_ACCEPT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      res_status_r <= res_status_nxt;
      res_id_r     <= res_id_nxt;
      res_lvl_r    <= res_lvl_nxt;
      res_fin_r    <= res_fin_nxt;
    end
    if (cmd.out_ld) begin
      if (cmd.out_hold) begin
        out_status_r <= res_status_r;
        out_id_r     <= res_id_r;
        out_lvl_r    <= res_lvl_r;
        out_fin_r    <= res_fin_r;
      end else begin
        out_status_r <= res_status_nxt;
        out_id_r     <= res_id_nxt;
        out_lvl_r    <= res_lvl_nxt;
        out_fin_r    <= res_fin_nxt;
      end
    end
  end

  assign out_tuser = out_status_r;
  assign out_tdata = {out_fin_r, out_lvl_r, out_id_r};

endmodule

[sv/multilevel_feedback_scheduler_unit.sv]
// top level of the multilevel feedback scheduler, quantum one
`timescale 1ns / 1ps
// Feedback scheduler with NUM_LEVELS priority levels of up to MAX_TASKS tasks each.
// An arrival beat (tuser 0) queues a task at level 0 or is rejected when MAX_TASKS
// tasks are active; a tick beat (tuser 1) first requeues the task preempted on the
// previous tick, then runs the head of the lowest-numbered non-empty level for one
// unit. Every input beat gives exactly one output beat. The sequencer steps through
// requeue write, level search with a registered read of the task memory, and pop;
// the result beat is loaded into the output register by the final step. A finished
// result waits in the output register while the next beat is taken; when that
// register is still occupied the new result is parked and the sequencer waits
// until the sink takes the older beat.
module multilevel_feedback_scheduler_unit import mlfs_pkg::*; #(
  parameter int MAX_TASKS  = 16,
  parameter int NUM_LEVELS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // task_id[3:0], service_need[19:4]
  input  logic                   in_tuser,   // opcode[0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // ran_id[3:0], ran_level[6:4], finished[7]
  output logic [1:0]             out_tuser   // status[1:0]
);

  cmd_t  cmd;
  stat_t stat;

  mlfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mlfs_dp #(
    .MAX_TASKS (MAX_TASKS),
    .NUM_LEVELS(NUM_LEVELS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_tuser (in_tuser),
    .in_tdata (in_tdata),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

endmodule
